>>> rtl/mavg_pkg.sv
// Shared constants and types for the moving average range check block.
// No dependencies; used by moving_average_range_check.
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

  // DEPTH must be a power of two: the average is a right shift by IDX_W.
  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int FILL_W   = $clog2(DEPTH + 1);
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = SAMPLE_W + IDX_W;
  localparam int REG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SANE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SANE = 1'b1;

  localparam logic [REG_W-1:0] MIN_SANE_RESET = '0;
  localparam logic [REG_W-1:0] MAX_SANE_RESET = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                in_range;
    logic                buffer_full;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/moving_average_range_check.sv
// Moving average over the last DEPTH distance samples with a sane-range check; uses mavg_pkg.
// Each result is registered into the output register, or into the skid stage when the
// output holds a stalled result. Throughput: one request per cycle while the skid stage is
// empty; the two-entry output accepts one more while a result waits on a stalled consumer.
// Reset: clears window sum, index, fill count and the per-entry valid bits of
// the ring at once (no clearing pass); limits go to 0 and 65535.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_range_check (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration
  input  wire logic                               cfg_write,
  input  wire logic [mavg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mavg_pkg::REG_W-1:0]         cfg_data,
  // request channel
  input  wire logic                               sample_valid,
  output logic                                    sample_stall,
  input  wire logic [mavg_pkg::SAMPLE_W-1:0]      sample,
  input  wire logic                               restart,
  // result channel
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic [mavg_pkg::SAMPLE_W-1:0]           average,
  output logic                                    in_range,
  output logic                                    buffer_full
);

  logic [mavg_pkg::REG_W-1:0]    min_sane;
  logic [mavg_pkg::REG_W-1:0]    max_sane;

  logic [mavg_pkg::SAMPLE_W-1:0] ring [mavg_pkg::DEPTH];
  logic [mavg_pkg::DEPTH-1:0]    ring_valid;
  logic [mavg_pkg::SUM_W-1:0]    window_sum;
  logic [mavg_pkg::IDX_W-1:0]    write_index;
  logic [mavg_pkg::FILL_W-1:0]   fill_count;

  logic                          accept;
  logic [mavg_pkg::SUM_W-1:0]    sum_base;
  logic [mavg_pkg::IDX_W-1:0]    slot;
  logic [mavg_pkg::FILL_W-1:0]   fill_base;
  logic [mavg_pkg::DEPTH-1:0]    valid_base;
  logic [mavg_pkg::SAMPLE_W-1:0] oldest;
  logic [mavg_pkg::SUM_W-1:0]    window_sum_next;
  logic [mavg_pkg::IDX_W-1:0]    write_index_next;
  logic [mavg_pkg::FILL_W-1:0]   fill_count_next;
  logic [mavg_pkg::DEPTH-1:0]    ring_valid_next;
  mavg_pkg::result_t             result_next;

  mavg_pkg::result_t             out_reg;
  logic                          out_valid;
  mavg_pkg::result_t             skid_reg;
  logic                          skid_valid;
  logic                          out_take;

  assign accept   = sample_valid && !sample_stall;
  assign out_take = out_valid && !result_stall;
  assign sample_stall = skid_valid;

  // Restart drops the window before this sample goes in.
  always_comb begin
    sum_base   = restart ? '0 : window_sum;
    slot       = restart ? '0 : write_index;
    fill_base  = restart ? '0 : fill_count;
    valid_base = restart ? '0 : ring_valid;
    oldest     = valid_base[slot] ? ring[slot] : '0;

    window_sum_next = sum_base - mavg_pkg::SUM_W'(oldest) + mavg_pkg::SUM_W'(sample);
    write_index_next = (slot == mavg_pkg::IDX_W'(mavg_pkg::DEPTH - 1)) ? '0
                                                                         : slot + 1'b1;
    fill_count_next = (fill_base < mavg_pkg::FILL_W'(mavg_pkg::DEPTH)) ? fill_base + 1'b1
                                                                         : fill_base;
    ring_valid_next = valid_base;
    ring_valid_next[slot] = 1'b1;

    result_next.average     = window_sum_next[mavg_pkg::SUM_W-1:mavg_pkg::IDX_W];
    result_next.in_range    = (result_next.average >= min_sane) &&
                              (result_next.average <= max_sane);
    result_next.buffer_full = (fill_count_next == mavg_pkg::FILL_W'(mavg_pkg::DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sane <= mavg_pkg::MIN_SANE_RESET;
      max_sane <= mavg_pkg::MAX_SANE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mavg_pkg::CFG_MIN_SANE: min_sane <= cfg_data;
        mavg_pkg::CFG_MAX_SANE: max_sane <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum  <= '0;
      write_index <= '0;
      fill_count  <= '0;
      ring_valid  <= '0;
    end else if (accept) begin
      window_sum  <= window_sum_next;
      write_index <= write_index_next;
      fill_count  <= fill_count_next;
      ring_valid  <= ring_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[slot] <= sample;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (accept) begin
        out_reg <= result_next;
      end
    end else if (accept) begin
      skid_reg <= result_next;
    end
  end

  assign result_valid = out_valid;
  assign average      = out_reg.average;
  assign in_range     = out_reg.in_range;
  assign buffer_full  = out_reg.buffer_full;

  // The skid stage only fills behind a held result.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid stage holds a result with the output register empty");

  // Until the ring wraps, each taken sample marks exactly one new entry.
  assert property (@(posedge clk) disable iff (rst)
    (fill_count < mavg_pkg::FILL_W'(mavg_pkg::DEPTH)) |->
    ($countones(ring_valid) == 32'(fill_count)))
    else $error("ring valid bits disagree with fill count");

  // An empty window has a zero sum.
  assert property (@(posedge clk) disable iff (rst)
    (fill_count == '0) |-> (window_sum == '0))
    else $error("window sum nonzero with an empty window");

  // A request taken behind a stalled result lands in the skid stage.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_stall && accept) |=> skid_valid)
    else $error("accepted request lost behind a stalled result");

endmodule

`default_nettype wire

>>> dv/moving_average_range_check_test.sv
// Testbench for moving_average_range_check: checks averages, range flags and fill
// flags against a cycle-free predictor under random idling and back-pressure.
// Depends on mavg_pkg and the moving_average_range_check RTL.
`timescale 1ns / 1ps

module moving_average_range_check_test;
  import mavg_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_SANE;
  logic [REG_W-1:0]     cfg_data = '0;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  logic [SAMPLE_W-1:0]  sample = '0;
  logic                 restart = 1'b0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [SAMPLE_W-1:0]  average;
  logic                 in_range;
  logic                 buffer_full;

  moving_average_range_check DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .restart(restart),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .average(average),
    .in_range(in_range),
    .buffer_full(buffer_full)
  );

  // Predictor state: window contents, exact sum, next slot, fill count, limits.
  logic [SAMPLE_W-1:0] window_ring [DEPTH];
  logic [SUM_W-1:0]    window_total = '0;
  logic [IDX_W-1:0]    next_slot = '0;
  int                  samples_taken = 0;
  logic [REG_W-1:0]    min_limit = MIN_SANE_RESET;
  logic [REG_W-1:0]    max_limit = MAX_SANE_RESET;

  result_t expected_averages[$];

  bit gap_enable = 1'b0;
  bit stall_enable = 1'b0;
  int holds_requested = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_left = 0;

  int errors = 0;
  int cycle_count = 0;
  int requests_sent = 0;
  int restarts_sent = 0;
  int limit_settings = 0;
  int results_seen = 0;
  int full_seen = 0;
  int rejected_seen = 0;

  initial begin
    foreach (window_ring[i]) window_ring[i] = '0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return SAMPLE_W'($urandom_range(0, 255));
      3: return SAMPLE_W'($urandom_range(16'hFF00, 16'hFFFF));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Advance the window by one sample and return the filtered reading.
  function automatic result_t filter_step(input logic [SAMPLE_W-1:0] value, input logic clear);
    result_t r;
    if (clear) begin
      foreach (window_ring[i]) window_ring[i] = '0;
      window_total = '0;
      next_slot = '0;
      samples_taken = 0;
    end
    window_total = window_total - SUM_W'(window_ring[next_slot]) + SUM_W'(value);
    window_ring[next_slot] = value;
    next_slot = next_slot + 1'b1;
    if (samples_taken < DEPTH) samples_taken++;
    r.average = SAMPLE_W'(window_total / DEPTH);
    r.in_range = (r.average >= min_limit) && (r.average <= max_limit);
    r.buffer_full = (samples_taken >= DEPTH);
    return r;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic clear);
    int gap;
    gap = (gap_enable && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    restart <= clear;
    do @(posedge clk); while (sample_stall);
    expected_averages.push_back(filter_step(value, clear));
    requests_sent++;
    if (clear) restarts_sent++;
  endtask

  // Drop valid, wait for every result, then let the pipeline settle.
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
    drain_results();
    write_register(CFG_MIN_SANE, lo);
    write_register(CFG_MAX_SANE, hi);
    min_limit = lo;
    max_limit = hi;
    limit_settings++;
  endtask

  task automatic run_random_traffic(input int count);
    repeat (count) send_sample(random_sample(), $urandom_range(0, 24) == 0);
  endtask

  // Fill the window with full-scale samples, wrap the index, then restart.
  task automatic test_window_fill();
    gap_enable = 1'b0;
    stall_enable = 1'b0;
    repeat (DEPTH) send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    send_sample('0, 1'b1);
    send_sample(16'h5555, 1'b0);
  endtask

  // Hit both limits exactly and one step outside, then inverted limits.
  task automatic test_limit_edges();
    set_limits(16'h0010, 16'h0020);
    send_sample(16'h0100, 1'b1);
    send_sample(16'h00FF, 1'b1);
    send_sample(16'h0200, 1'b1);
    send_sample(16'h0210, 1'b1);
    set_limits(16'h0001, 16'h0000);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0010, 1'b1);
  endtask

  task automatic test_random_traffic();
    int lo;
    set_limits(MIN_SANE_RESET, MAX_SANE_RESET);
    run_random_traffic(200);
    gap_enable = 1'b1;
    stall_enable = 1'b1;
    set_limits(16'h0000, 16'h0000);
    run_random_traffic(200);
    set_limits(16'hFFFF, 16'hFFFF);
    run_random_traffic(200);
    lo = $urandom_range(1, 65535);
    set_limits(REG_W'(lo), REG_W'($urandom_range(0, lo - 1)));
    run_random_traffic(200);
    gap_enable = 1'b0;
    lo = $urandom_range(0, 40000);
    set_limits(REG_W'(lo), REG_W'($urandom_range(lo, 65535)));
    run_random_traffic(200);
    gap_enable = 1'b1;
    stall_enable = 1'b0;
    lo = $urandom_range(20000, 32768);
    set_limits(REG_W'(lo), REG_W'(lo + $urandom_range(0, 8000)));
    run_random_traffic(200);
  endtask

  // Hold the result side for a long stretch while requests keep coming.
  task automatic test_backpressure();
    gap_enable = 1'b0;
    stall_enable = 1'b0;
    holds_requested++;
    run_random_traffic(50);
    drain_results();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (holds_requested != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (!stall_enable) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      result_stall <= ($urandom_range(0, 3) == 0);
      stall_left <= idle_length();
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (buffer_full) full_seen++;
      if (!in_range) rejected_seen++;
      if (expected_averages.size() == 0) begin
        $display("%0t: result with nothing pending: average %h in_range %b buffer_full %b",
                 $time, average, in_range, buffer_full);
        errors++;
      end else begin
        want = expected_averages.pop_front();
        if (average !== want.average) begin
          $display("%0t: average expected %h, got %h", $time, want.average, average);
          errors++;
        end
        if (in_range !== want.in_range) begin
          $display("%0t: in_range expected %b, got %b", $time, want.in_range, in_range);
          errors++;
        end
        if (buffer_full !== want.buffer_full) begin
          $display("%0t: buffer_full expected %b, got %b", $time, want.buffer_full,
                   buffer_full);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results pending", $time, cycle_count,
               expected_averages.size());
      $display("** moving_average_range_check: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_window_fill();
    test_limit_edges();
    test_random_traffic();
    test_backpressure();
    drain_results();
    repeat (5) @(posedge clk);
    $display("Sent %0d requests (%0d restarts) across %0d limit settings;", requests_sent,
             restarts_sent, limit_settings);
    $display("checked %0d results: %0d with a full window, %0d out of range.", results_seen,
             full_seen, rejected_seen);
    if (errors == 0) begin
      $display("** moving_average_range_check: PASSED **");
    end else begin
      $display("** moving_average_range_check: FAILED **");
    end
    $finish;
  end

endmodule
